/* rtl/core/bkv_pkg.sv */
// Shared types and constants for the bucketed key-value table.
// No dependencies; imported by the top level, the front end and the back end.
`default_nettype none

package bkv_pkg;

    localparam int KEY_W   = 20;
    localparam int VALUE_W = 31;
    localparam int READ_W  = 32;

    typedef enum logic [1:0] {
        ACT_GET    = 2'd0,
        ACT_PUT    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
    } item_t;

    typedef struct packed {
        logic                     found;
        logic signed [READ_W-1:0] read_value;
        logic                     bucket_full;
    } result_t;

    localparam logic signed [READ_W-1:0] READ_NONE = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/bucketed_key_value_table.sv */
// Top level of the bucketed key-value table: front end, operation queue
// and back end. Depends on bkv_pkg, bkv_front and bkv_back.
//
// Usage:
//   s_ channel carries one operation per transaction: get, put, remove or no-op
//   (s_tuser) on a key and value (s_tdata). m_ channel returns exactly one
//   result per operation, in order: found, read value, bucket full.
//   Path: each result passes through the queue, the bucket row read and
//   the result register before it shows on m_tvalid.
//   Order: the back end takes one operation at a time from the queue, set
//   by the bucket memory: it reads the bucket row, then compares all ways
//   and writes the row back before it takes the next operation.
//   Reset: a clearing pass writes every bucket row to empty; s_tready
//   stays low until it is done.
//   Stall: while m_tready is low the result register holds; the queue
//   keeps taking up to two operations before s_tready drops.
//   BUCKETS must be a power of two.
`default_nettype none

module bucketed_key_value_table #(
    parameter int BUCKETS  = 512,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key[19:0], value[50:20], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // found[0], read_value[32:1], bucket_full[33], zero pad
);
    import bkv_pkg::*;

    logic    q_valid, pop, clearing;
    item_t   q_item;
    result_t res;

    bkv_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .s_key    (s_tdata[KEY_W-1:0]),
        .s_value  (s_tdata[KEY_W +: VALUE_W]),
        .enable   (!clearing),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    bkv_back #(
        .BUCKETS  (BUCKETS),
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .clearing (clearing),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {6'b0, res.bucket_full, res.read_value, res.found};

endmodule

`default_nettype wire

/* rtl/core/bkv_front.sv */
// Front end: accepts input transactions, decodes the action, masks the key
// and holds operations in a two-entry queue. Depends on bkv_pkg.
`default_nettype none

module bkv_front #(
    parameter int KEY_BITS = 20
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [1:0]                  s_action,
    input  logic [bkv_pkg::KEY_W-1:0]   s_key,
    input  logic [bkv_pkg::VALUE_W-1:0] s_value,
    input  logic                        enable,
    input  logic                        pop,
    output logic                        q_valid,
    output bkv_pkg::item_t              q_item
);
    import bkv_pkg::*;

    item_t       q_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       in_item;
    logic        push;

    // keys are truncated to KEY_BITS before hashing or compare
    always_comb begin
        in_item.action = action_t'(s_action);
        in_item.value  = s_value;
        for (int i = 0; i < KEY_W; i++) begin
            in_item.key[i] = s_key[i] & (i < KEY_BITS);
        end
    end

    assign s_tready = enable && (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bkv_back.sv */
// Back end: bucket memory, clearing pass after reset, way compare and
// write back, and the result register. Depends on bkv_pkg.
`default_nettype none

module bkv_back #(
    parameter int BUCKETS  = 512,
    parameter int WAYS     = 4,
    parameter int KEY_BITS = 20
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  bkv_pkg::item_t  q_item,
    output logic            pop,
    output logic            clearing,
    output logic            m_valid,
    input  logic            m_ready,
    output bkv_pkg::result_t m_res
);
    import bkv_pkg::*;

    // BUCKETS must be a power of two, which the block does not check: the bucket is the low key bits
    localparam int BW    = $clog2(BUCKETS);
    localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int EW    = VALUE_W + KW + 1;   // per way: value, key, valid on top
    localparam int ROW_W = WAYS * EW;

    logic [ROW_W-1:0] mem [BUCKETS];
    logic [ROW_W-1:0] rdata_reg;

    back_state_t      state_reg, state_next;
    logic [BW-1:0]    clr_reg, clr_next;
    item_t            cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    result_t          res_reg, res_next;

    logic             we, re;
    logic [BW-1:0]    waddr, raddr;
    logic [ROW_W-1:0] wdata;

    logic [WAYS-1:0]    hit, free_oh;
    logic               found, free_any;
    logic [VALUE_W-1:0] hit_val;
    logic [ROW_W-1:0]   new_row;
    result_t            look_res;

    // way compare on the row read for the current operation
    always_comb begin
        hit      = '0;
        free_oh  = '0;
        free_any = 1'b0;
        hit_val  = '0;
        new_row  = rdata_reg;
        for (int w = 0; w < WAYS; w++) begin
            hit[w] = rdata_reg[w*EW + EW - 1]
                     && (rdata_reg[w*EW + VALUE_W +: KW] == cur_reg.key[KW-1:0]);
            if (hit[w]) begin
                hit_val = hit_val | rdata_reg[w*EW +: VALUE_W];
            end
            if (!rdata_reg[w*EW + EW - 1] && !free_any) begin
                free_oh[w] = 1'b1;
                free_any   = 1'b1;
            end
        end
        found = |hit;
        for (int w = 0; w < WAYS; w++) begin
            if (cur_reg.action == ACT_PUT) begin
                if (hit[w] || (!found && free_oh[w])) begin
                    new_row[w*EW +: VALUE_W]      = cur_reg.value;
                    new_row[w*EW + VALUE_W +: KW] = cur_reg.key[KW-1:0];
                    new_row[w*EW + EW - 1]        = 1'b1;
                end
            end else if (cur_reg.action == ACT_REMOVE) begin
                if (hit[w]) begin
                    new_row[w*EW + EW - 1] = 1'b0;
                end
            end
        end
        look_res.found       = found;
        look_res.read_value  = ((cur_reg.action == ACT_GET) && found)
                               ? $signed({1'b0, hit_val}) : READ_NONE;
        look_res.bucket_full = (cur_reg.action == ACT_PUT) && !found && !free_any;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pop          = 1'b0;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = cur_reg.key[BW-1:0];
        raddr        = q_item.key[BW-1:0];
        wdata        = new_row;
        case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    re         = 1'b1;
                    cur_next   = q_item;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!m_valid_reg || m_ready) begin
                    we           = (cur_reg.action == ACT_PUT)
                                   || (cur_reg.action == ACT_REMOVE);
                    res_next     = look_res;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire

/* rtl/core/bkv_checker.sv */
// Port-level assertions for the bucketed key-value table, bound to the
// top level. No package dependency.
`default_nettype none

module bkv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // clearing pass blocks input right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("s_tready high right after reset");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_absent_reads_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'hFFFF_FFFF)
        else $error("read value without a hit");

    a_full_means_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> !m_tdata[0])
        else $error("bucket full reported on a present key");

endmodule

bind bucketed_key_value_table bkv_checker u_bkv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
